// ===== rtl/cpfw_pkg.sv =====
// shared types, register indexes, format codes and luma constants
// for the clipped pixel format writer; no dependencies
`timescale 1ns / 1ps

package cpfw_pkg;

  localparam int STORE_AW      = 16;
  localparam int FB_WIDTH_DEF  = 128;
  localparam int FB_HEIGHT_DEF = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT  = 3'd5;

  localparam logic signed [15:0] CLIP_SIZE_RST = 16'sd128;

  // luma = (299r + 587g + 114b) / 1000, division by a reciprocal scaled by 2^28, rounded up
  localparam int SUM_W      = 18;
  localparam int RECIP_W    = 19;
  localparam int LUMA_SHIFT = 28;
  localparam logic [9:0]         LUMA_KR    = 10'd299;
  localparam logic [9:0]         LUMA_KG    = 10'd587;
  localparam logic [9:0]         LUMA_KB    = 10'd114;
  localparam logic [RECIP_W-1:0] LUMA_RECIP = 19'd268436;

  typedef enum logic [2:0] {
    FMT_RGB888   = 3'd0,
    FMT_ARGB8888 = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_BGR565   = 3'd3,
    FMT_MONO01   = 3'd4,
    FMT_MONO10   = 3'd5,
    FMT_LUMA8    = 3'd6,
    FMT_NONE     = 3'd7
  } cpfw_fmt_t;

  typedef enum logic [0:0] {
    CMD_DRAW = 1'b0,
    CMD_READ = 1'b1
  } cpfw_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_WRITE,
    ST_RESULT
  } cpfw_state_t;

  typedef struct packed {
    cpfw_cmd_t          command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        read_address;
  } cpfw_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_written;
  } cpfw_out_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic [15:0] rgb565;
    logic [15:0] bgr565;
  } cpfw_color_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } cpfw_wr_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } cpfw_rd_t;

endpackage

// ===== rtl/cpfw_if.sv =====
// valid/ready stream interface with a typed payload
// used for the command and result channels; no dependencies
`timescale 1ns / 1ps

interface cpfw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/cpfw_color.sv =====
// color conversion: rgb565/bgr565 packing and two-stage luma
// depends on cpfw_pkg
`timescale 1ns / 1ps

module cpfw_color (
  input  logic                  clk,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output cpfw_pkg::cpfw_color_t color
);

  localparam int ProdW = cpfw_pkg::SUM_W + cpfw_pkg::RECIP_W;

  logic [cpfw_pkg::SUM_W-1:0] sum_r;
  logic [cpfw_pkg::SUM_W-1:0] sum_nxt;
  logic [ProdW-1:0]           prod;
  logic [7:0]                 luma_r;
  logic [15:0]                rgb_r;
  logic [15:0]                bgr_r;

  assign sum_nxt = cpfw_pkg::SUM_W'(cpfw_pkg::LUMA_KR) * cpfw_pkg::SUM_W'(red)
                 + cpfw_pkg::SUM_W'(cpfw_pkg::LUMA_KG) * cpfw_pkg::SUM_W'(green)
                 + cpfw_pkg::SUM_W'(cpfw_pkg::LUMA_KB) * cpfw_pkg::SUM_W'(blue);

  assign prod = ProdW'(sum_r) * ProdW'(cpfw_pkg::LUMA_RECIP);

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    rgb_r  <= {red[7:3], green[7:2], blue[7:3]};
    bgr_r  <= {blue[7:3], green[7:2], red[7:3]};
    luma_r <= prod[cpfw_pkg::LUMA_SHIFT +: 8];
  end

  assign color.luma   = luma_r;
  assign color.rgb565 = rgb_r;
  assign color.bgr565 = bgr_r;

endmodule

// ===== rtl/cpfw_fstore.sv =====
// 64 KiB byte frame store, one write and one registered read port
// clears itself after reset, one byte a cycle; depends on cpfw_pkg
`timescale 1ns / 1ps

module cpfw_fstore (
  input  logic               clk,
  input  logic               rst_n,
  input  cpfw_pkg::cpfw_wr_t wr,
  input  cpfw_pkg::cpfw_rd_t rd,
  output logic [7:0]         rd_data,
  output logic               clr_busy
);

  localparam int AW    = cpfw_pkg::STORE_AW;
  localparam int Depth = 2 ** AW;

  logic [7:0]    mem [Depth];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

  a_clr_runs: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r && (clr_cnt_r != '1) |=> clr_busy_r)
    else $error("clear sweep stopped early");

  a_clr_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_cnt_r) == '1)
    else $error("clear sweep ended before last byte");

  a_no_wr_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !wr.en)
    else $error("write during clear sweep");

endmodule

// ===== rtl/clipped_pixel_format_writer_core.sv =====
// clipped pixel format writer top: config registers, sequencer, store, color
// read: IDLE, CALC1 (read), CALC2, RESULT; kept draws not in format NONE add
// WRITE per byte (1 to 4) before RESULT, which waits for a free output register;
// the next command is taken when the previous one has left the sequencer; one
// write port (one byte a cycle); no command taken during the 65536-byte store clear
// synchronous reset; depends on cpfw_pkg, cpfw_if, cpfw_color, cpfw_fstore
`timescale 1ns / 1ps

module clipped_pixel_format_writer_core #(
  parameter int FB_WIDTH  = cpfw_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = cpfw_pkg::FB_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cpfw_stream_if.sink                      in_stream,
  cpfw_stream_if.source                    out_stream,
  input  logic                             cfg_wr_en,
  input  logic [cpfw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpfw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW       = cpfw_pkg::STORE_AW;
  localparam int RowBytes = (FB_WIDTH + 7) / 8;
  localparam logic signed [16:0] FbWidthS  = 17'(FB_WIDTH);
  localparam logic signed [16:0] FbHeightS = 17'(FB_HEIGHT);
  localparam logic [AW-1:0]      FbWidthA  = AW'(FB_WIDTH);
  localparam logic [AW-1:0]      RowBytesA = AW'(RowBytes);

  // configuration registers
  cpfw_pkg::cpfw_fmt_t fmt_r;
  logic                clip_en_r;
  logic signed [15:0]  clip_left_r;
  logic signed [15:0]  clip_top_r;
  logic signed [15:0]  clip_width_r;
  logic signed [15:0]  clip_height_r;

  cpfw_pkg::cpfw_state_t state_r;
  cpfw_pkg::cpfw_state_t state_nxt;

  cpfw_pkg::cpfw_in_t    item_r;
  cpfw_pkg::cpfw_out_t   out_r;
  cpfw_pkg::cpfw_out_t   res_nxt;
  cpfw_pkg::cpfw_color_t color;
  cpfw_pkg::cpfw_wr_t    wr;
  cpfw_pkg::cpfw_rd_t    rd;

  logic          out_valid_r;
  logic          out_load;
  logic          in_ready;
  logic          in_xfer;
  logic          clr_busy;
  logic [7:0]    rd_data;

  logic          keep_r;
  logic          keep_nxt;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] pos_nxt;
  logic [AW-1:0] mono_addr_r;
  logic [AW-1:0] mono_addr_nxt;
  logic [AW-1:0] base_addr_r;
  logic [AW-1:0] base_addr_nxt;
  logic [1:0]    last_idx_r;
  logic [1:0]    last_idx_nxt;
  logic [1:0]    idx_r;
  logic          wr_ok_r;
  logic          wr_ok_nxt;
  logic          is_mono;
  logic          mono_bit;
  logic [7:0]    mono_mask;
  logic [7:0]    byte_data;

  logic signed [16:0] x17;
  logic signed [16:0] y17;
  logic signed [16:0] clip_right;
  logic signed [16:0] clip_bottom;
  logic               in_disp;
  logic               in_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r         <= cpfw_pkg::FMT_RGB888;
      clip_en_r     <= 1'b0;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= cpfw_pkg::CLIP_SIZE_RST;
      clip_height_r <= cpfw_pkg::CLIP_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cpfw_pkg::CFG_PIXEL_FORMAT: fmt_r <= cpfw_pkg::cpfw_fmt_t'(cfg_wdata[2:0]);
        cpfw_pkg::CFG_CLIP_ENABLE:  clip_en_r     <= cfg_wdata[0];
        cpfw_pkg::CFG_CLIP_LEFT:    clip_left_r   <= $signed(cfg_wdata);
        cpfw_pkg::CFG_CLIP_TOP:     clip_top_r    <= $signed(cfg_wdata);
        cpfw_pkg::CFG_CLIP_WIDTH:   clip_width_r  <= $signed(cfg_wdata);
        cpfw_pkg::CFG_CLIP_HEIGHT:  clip_height_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  cpfw_color u_color (
    .clk   (clk),
    .red   (item_r.red),
    .green (item_r.green),
    .blue  (item_r.blue),
    .color (color)
  );

  cpfw_fstore u_fstore (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd       (rd),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  // position tests and linear addresses
  assign x17         = {item_r.pos_x[15], item_r.pos_x};
  assign y17         = {item_r.pos_y[15], item_r.pos_y};
  assign clip_right  = {clip_left_r[15], clip_left_r} + {clip_width_r[15], clip_width_r};
  assign clip_bottom = {clip_top_r[15], clip_top_r} + {clip_height_r[15], clip_height_r};

  assign in_disp = !item_r.pos_x[15] && !item_r.pos_y[15]
                && (x17 < FbWidthS) && (y17 < FbHeightS);
  assign in_clip = (item_r.pos_x >= clip_left_r) && (item_r.pos_y >= clip_top_r)
                && (x17 < clip_right) && (y17 < clip_bottom);
  assign keep_nxt = (item_r.command == cpfw_pkg::CMD_DRAW) && in_disp
                 && (!clip_en_r || in_clip);

  assign pos_nxt       = AW'($unsigned(item_r.pos_y)) * FbWidthA
                       + AW'($unsigned(item_r.pos_x));
  assign mono_addr_nxt = AW'($unsigned(item_r.pos_y)) * RowBytesA
                       + (AW'($unsigned(item_r.pos_x)) >> 3);

  assign is_mono   = (fmt_r == cpfw_pkg::FMT_MONO01) || (fmt_r == cpfw_pkg::FMT_MONO10);
  assign wr_ok_nxt = keep_r && (fmt_r != cpfw_pkg::FMT_NONE);

  always_comb begin
    case (fmt_r)
      cpfw_pkg::FMT_RGB888: begin
        base_addr_nxt = pos_r + (pos_r << 1);
        last_idx_nxt  = 2'd2;
      end
      cpfw_pkg::FMT_ARGB8888: begin
        base_addr_nxt = pos_r << 2;
        last_idx_nxt  = 2'd3;
      end
      cpfw_pkg::FMT_RGB565, cpfw_pkg::FMT_BGR565: begin
        base_addr_nxt = pos_r << 1;
        last_idx_nxt  = 2'd1;
      end
      cpfw_pkg::FMT_MONO01, cpfw_pkg::FMT_MONO10: begin
        base_addr_nxt = mono_addr_r;
        last_idx_nxt  = 2'd0;
      end
      default: begin
        base_addr_nxt = pos_r;
        last_idx_nxt  = 2'd0;
      end
    endcase
  end

  // byte to store for the current write cycle
  assign mono_bit  = color.luma[7] ^ (fmt_r == cpfw_pkg::FMT_MONO10);
  assign mono_mask = 8'h80 >> item_r.pos_x[2:0];

  always_comb begin
    case (fmt_r)
      cpfw_pkg::FMT_RGB888: begin
        case (idx_r)
          2'd0:    byte_data = item_r.red;
          2'd1:    byte_data = item_r.green;
          default: byte_data = item_r.blue;
        endcase
      end
      cpfw_pkg::FMT_ARGB8888: begin
        case (idx_r)
          2'd0:    byte_data = item_r.alpha;
          2'd1:    byte_data = item_r.red;
          2'd2:    byte_data = item_r.green;
          default: byte_data = item_r.blue;
        endcase
      end
      cpfw_pkg::FMT_RGB565: begin
        byte_data = (idx_r == 2'd0) ? color.rgb565[15:8] : color.rgb565[7:0];
      end
      cpfw_pkg::FMT_BGR565: begin
        byte_data = (idx_r == 2'd0) ? color.bgr565[15:8] : color.bgr565[7:0];
      end
      cpfw_pkg::FMT_MONO01, cpfw_pkg::FMT_MONO10: begin
        byte_data = mono_bit ? (rd_data | mono_mask) : (rd_data & ~mono_mask);
      end
      default: byte_data = color.luma;
    endcase
  end

  assign res_nxt.read_data     = (item_r.command == cpfw_pkg::CMD_READ) ? rd_data : 8'd0;
  assign res_nxt.pixel_written = (item_r.command == cpfw_pkg::CMD_DRAW) && wr_ok_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpfw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    rd        = '0;
    wr        = '0;
    case (state_r)
      cpfw_pkg::ST_IDLE: begin
        in_ready = !clr_busy;
        if (in_stream.valid && !clr_busy) begin
          state_nxt = cpfw_pkg::ST_CALC1;
        end
      end
      cpfw_pkg::ST_CALC1: begin
        if (item_r.command == cpfw_pkg::CMD_READ) begin
          rd.en   = 1'b1;
          rd.addr = item_r.read_address;
        end
        state_nxt = cpfw_pkg::ST_CALC2;
      end
      cpfw_pkg::ST_CALC2: begin
        if (wr_ok_nxt && is_mono) begin
          rd.en   = 1'b1;
          rd.addr = mono_addr_r;
        end
        state_nxt = wr_ok_nxt ? cpfw_pkg::ST_WRITE : cpfw_pkg::ST_RESULT;
      end
      cpfw_pkg::ST_WRITE: begin
        wr.en   = 1'b1;
        wr.addr = base_addr_r + AW'(idx_r);
        wr.data = byte_data;
        if (idx_r == last_idx_r) begin
          state_nxt = cpfw_pkg::ST_RESULT;
        end
      end
      cpfw_pkg::ST_RESULT: begin
        if (!out_valid_r || out_stream.ready) begin
          out_load  = 1'b1;
          state_nxt = cpfw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpfw_pkg::ST_IDLE;
    endcase
  end

  assign in_stream.ready = in_ready;
  assign in_xfer         = in_stream.valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_stream.payload;
    end
    if (state_r == cpfw_pkg::ST_CALC1) begin
      keep_r      <= keep_nxt;
      pos_r       <= pos_nxt;
      mono_addr_r <= mono_addr_nxt;
    end
    if (state_r == cpfw_pkg::ST_CALC2) begin
      base_addr_r <= base_addr_nxt;
      last_idx_r  <= last_idx_nxt;
      wr_ok_r     <= wr_ok_nxt;
      idx_r       <= '0;
    end else if (state_r == cpfw_pkg::ST_WRITE) begin
      idx_r <= idx_r + 2'd1;
    end
    if (out_load) begin
      out_r <= res_nxt;
    end
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_r;

  a_wr_only_kept: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == cpfw_pkg::ST_WRITE) && wr_ok_r)
    else $error("store write for a dropped pixel");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpfw_pkg::ST_WRITE) |-> (idx_r <= last_idx_r))
    else $error("byte index past pixel size");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid && out_stream.payload.pixel_written |->
      out_stream.payload.read_data == 8'd0)
    else $error("draw result carries read data");

  a_idle_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> (state_r == cpfw_pkg::ST_IDLE))
    else $error("command in flight during clear sweep");

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for clipped_pixel_format_writer_core: directed table, then
// random phases under new register settings, each result checked against a fixed value or a frame model
// depends on cpfw_pkg, cpfw_if and the core rtl
`timescale 1ns / 1ps

module testbench;

  localparam int FB_W = cpfw_pkg::FB_WIDTH_DEF;
  localparam int FB_H = cpfw_pkg::FB_HEIGHT_DEF;
  localparam int DRAIN_GAP = 8;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 40;

  typedef struct {
    bit                  is_reg;
    logic [2:0]          reg_idx;
    logic [15:0]         reg_val;
    cpfw_pkg::cpfw_in_t  cmd;
    bit                  typed;
    cpfw_pkg::cpfw_out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [cpfw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cpfw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cpfw_stream_if #(.payload_t(cpfw_pkg::cpfw_in_t)) cmd_if ();
  cpfw_stream_if #(.payload_t(cpfw_pkg::cpfw_out_t)) res_if ();

  clipped_pixel_format_writer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (cmd_if),
    .out_stream (res_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // frame model state
  logic [7:0]          frame_copy [0:65535];
  cpfw_pkg::cpfw_fmt_t fmt_q;
  logic                clip_on;
  int                  clip_l, clip_t, clip_w, clip_h;
  int unsigned         last_store_addr;

  cpfw_pkg::cpfw_out_t awaited_results [$];
  cpfw_pkg::cpfw_out_t head_result;
  stim_row_t           plan [$];
  int                  fail_count;
  bit                  stall_on;
  int                  random_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    res_if.ready <= !(stall_on && $urandom_range(99) < 7);
  end

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        note_fail($sformatf("unexpected result: read_data %02h pixel_written %0b",
                            res_if.payload.read_data, res_if.payload.pixel_written));
      end else begin
        head_result = awaited_results.pop_front();
        if (res_if.payload.read_data !== head_result.read_data)
          note_fail($sformatf("read_data: expected %02h got %02h",
                              head_result.read_data, res_if.payload.read_data));
        if (res_if.payload.pixel_written !== head_result.pixel_written)
          note_fail($sformatf("pixel_written: expected %0b got %0b",
                              head_result.pixel_written, res_if.payload.pixel_written));
      end
    end
  end

  function automatic void store_byte(int unsigned addr, logic [7:0] val);
    frame_copy[addr[15:0]] = val;
    last_store_addr = addr[15:0];
  endfunction

  function automatic cpfw_pkg::cpfw_out_t predict_pixel_result(cpfw_pkg::cpfw_in_t it);
    cpfw_pkg::cpfw_out_t res;
    int                  x, y;
    int unsigned         pos, luma, maddr;
    logic [15:0]         c565;
    logic                mono;
    res = '0;
    if (it.command == cpfw_pkg::CMD_READ) begin
      res.read_data = frame_copy[it.read_address];
      return res;
    end
    x = $signed(it.pos_x);
    y = $signed(it.pos_y);
    if (x < 0 || y < 0 || x >= FB_W || y >= FB_H) return res;
    if (clip_on && (x < clip_l || y < clip_t || x >= clip_l + clip_w ||
                    y >= clip_t + clip_h)) return res;
    pos  = y * FB_W + x;
    luma = (299 * it.red + 587 * it.green + 114 * it.blue) / 1000;
    case (fmt_q)
      cpfw_pkg::FMT_RGB888: begin
        store_byte(pos * 3, it.red);
        store_byte(pos * 3 + 1, it.green);
        store_byte(pos * 3 + 2, it.blue);
      end
      cpfw_pkg::FMT_ARGB8888: begin
        store_byte(pos * 4, it.alpha);
        store_byte(pos * 4 + 1, it.red);
        store_byte(pos * 4 + 2, it.green);
        store_byte(pos * 4 + 3, it.blue);
      end
      cpfw_pkg::FMT_RGB565, cpfw_pkg::FMT_BGR565: begin
        c565 = (fmt_q == cpfw_pkg::FMT_RGB565)
             ? {it.red[7:3], it.green[7:2], it.blue[7:3]}
             : {it.blue[7:3], it.green[7:2], it.red[7:3]};
        store_byte(pos * 2, c565[15:8]);
        store_byte(pos * 2 + 1, c565[7:0]);
      end
      cpfw_pkg::FMT_MONO01, cpfw_pkg::FMT_MONO10: begin
        mono  = (luma > 127) ^ (fmt_q == cpfw_pkg::FMT_MONO10);
        maddr = y * ((FB_W + 7) / 8) + x / 8;
        frame_copy[maddr[15:0]][7 - (x % 8)] = mono;
        last_store_addr = maddr[15:0];
      end
      cpfw_pkg::FMT_LUMA8: store_byte(pos, luma[7:0]);
      default: return res;
    endcase
    res.pixel_written = 1'b1;
    return res;
  endfunction

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      cpfw_pkg::CFG_PIXEL_FORMAT: fmt_q = cpfw_pkg::cpfw_fmt_t'(val[2:0]);
      cpfw_pkg::CFG_CLIP_ENABLE:  clip_on = val[0];
      cpfw_pkg::CFG_CLIP_LEFT:    clip_l = $signed(val);
      cpfw_pkg::CFG_CLIP_TOP:     clip_t = $signed(val);
      cpfw_pkg::CFG_CLIP_WIDTH:   clip_w = $signed(val);
      cpfw_pkg::CFG_CLIP_HEIGHT:  clip_h = $signed(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_cmd(cpfw_pkg::cpfw_in_t it, bit typed, cpfw_pkg::cpfw_out_t want);
    cpfw_pkg::cpfw_out_t got;
    if (stall_on && $urandom_range(99) < 7) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= it;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    got = predict_pixel_result(it);
    awaited_results.push_back(typed ? want : got);
  endtask

  function automatic void add_reg(logic [2:0] idx, logic [15:0] val);
    stim_row_t row;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.cmd     = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_draw(int x, int y, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic [7:0] a, bit typed, bit pw);
    stim_row_t row;
    row.is_reg           = 1'b0;
    row.reg_idx          = '0;
    row.reg_val          = '0;
    row.cmd              = '0;
    row.cmd.command      = cpfw_pkg::CMD_DRAW;
    row.cmd.pos_x        = 16'(x);
    row.cmd.pos_y        = 16'(y);
    row.cmd.red          = r;
    row.cmd.green        = g;
    row.cmd.blue         = b;
    row.cmd.alpha        = a;
    row.typed            = typed;
    row.want             = '0;
    row.want.pixel_written = pw;
    plan.push_back(row);
  endfunction

  function automatic void add_read(logic [15:0] addr, bit typed, logic [7:0] rd);
    stim_row_t row;
    row.is_reg           = 1'b0;
    row.reg_idx          = '0;
    row.reg_val          = '0;
    row.cmd              = '0;
    row.cmd.command      = cpfw_pkg::CMD_READ;
    row.cmd.read_address = addr;
    row.typed            = typed;
    row.want             = '0;
    row.want.read_data   = rd;
    plan.push_back(row);
  endfunction

  function automatic int near_border(int lo, int span);
    case ($urandom_range(3))
      0: return lo - 1;
      1: return lo;
      2: return lo + span - 1;
      default: return lo + span;
    endcase
  endfunction

  function automatic cpfw_pkg::cpfw_in_t random_cmd();
    cpfw_pkg::cpfw_in_t it;
    int unsigned        sel;
    it.command = ($urandom_range(99) < 35) ? cpfw_pkg::CMD_READ : cpfw_pkg::CMD_DRAW;
    it.red     = 8'($urandom);
    it.green   = 8'($urandom);
    it.blue    = 8'($urandom);
    it.alpha   = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 75) begin
      it.pos_x = 16'($urandom_range(0, FB_W - 1));
      it.pos_y = 16'($urandom_range(0, FB_H - 1));
    end else if (sel < 90) begin
      it.pos_x = 16'(($urandom_range(1) && clip_on) ? near_border(clip_l, clip_w)
                                                    : near_border(0, FB_W));
      it.pos_y = 16'(($urandom_range(1) && clip_on) ? near_border(clip_t, clip_h)
                                                    : near_border(0, FB_H));
    end else begin
      it.pos_x = 16'($urandom);
      it.pos_y = 16'($urandom);
    end
    it.read_address = ($urandom_range(99) < 60) ? 16'(last_store_addr + $urandom_range(0, 3))
                                                : 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] clip_origin();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'(int'($urandom_range(0, 140)) - 10);
    endcase
  endfunction

  function automatic logic [15:0] clip_span();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(-int'($urandom_range(1, 20)));
      default: return 16'($urandom_range(0, 130));
    endcase
  endfunction

  initial begin
    rst_n          <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    foreach (frame_copy[i]) frame_copy[i] = 8'h00;
    fmt_q           = cpfw_pkg::FMT_RGB888;
    clip_on         = 1'b0;
    clip_l          = 0;
    clip_t          = 0;
    clip_w          = cpfw_pkg::CLIP_SIZE_RST;
    clip_h          = cpfw_pkg::CLIP_SIZE_RST;
    last_store_addr = 0;
    fail_count      = 0;
    random_sent     = 0;
    stall_on        = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset state and display bounds
    add_read(16'h0000, 1, 8'h00);
    add_read(16'hFFFF, 1, 8'h00);
    add_draw(-32768, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0);
    add_draw(0, 32767, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0);
    add_draw(FB_W, 5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0);
    add_draw(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1);
    add_read(16'h0000, 1, 8'hFF);
    add_draw(FB_W - 1, FB_H - 1, 8'h12, 8'h34, 8'h56, 8'h00, 0, 0);
    add_read(16'((FB_W * FB_H - 1) * 3 + 2), 0, 8'h00);
    // each format
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_ARGB8888));
    add_draw(1, 0, 8'h01, 8'h02, 8'h03, 8'h04, 0, 0);
    add_read(16'd4, 1, 8'h04);
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_RGB565));
    add_draw(2, 0, 8'hFF, 8'h00, 8'hFF, 8'h00, 0, 0);
    add_read(16'd4, 0, 8'h00);
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_BGR565));
    add_draw(3, 0, 8'h80, 8'hFF, 8'h08, 8'h00, 0, 0);
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_MONO01));
    add_draw(8, 1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1, 1);
    add_read(16'(((FB_W + 7) / 8) + 1), 1, 8'h80);
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_MONO10));
    add_draw(9, 1, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1);
    add_read(16'(((FB_W + 7) / 8) + 1), 1, 8'hC0);
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_LUMA8));
    add_draw(0, 2, 8'hFF, 8'h00, 8'h00, 8'h00, 0, 0);
    add_read(16'(2 * FB_W), 0, 8'h00);
    // format none stores nothing
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_NONE));
    add_draw(1, 2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0);
    // clip rectangle edges, negative width, extreme left plus width
    add_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'(cpfw_pkg::FMT_RGB888));
    add_reg(cpfw_pkg::CFG_CLIP_ENABLE, 16'd1);
    add_reg(cpfw_pkg::CFG_CLIP_LEFT, 16'd10);
    add_reg(cpfw_pkg::CFG_CLIP_TOP, 16'd10);
    add_reg(cpfw_pkg::CFG_CLIP_WIDTH, 16'd5);
    add_reg(cpfw_pkg::CFG_CLIP_HEIGHT, 16'd5);
    add_draw(9, 10, 8'h11, 8'h22, 8'h33, 8'h44, 1, 0);
    add_draw(14, 14, 8'h11, 8'h22, 8'h33, 8'h44, 1, 1);
    add_draw(15, 12, 8'h11, 8'h22, 8'h33, 8'h44, 1, 0);
    add_reg(cpfw_pkg::CFG_CLIP_WIDTH, 16'hFFFF);
    add_draw(12, 12, 8'h11, 8'h22, 8'h33, 8'h44, 1, 0);
    add_reg(cpfw_pkg::CFG_CLIP_LEFT, 16'h8000);
    add_reg(cpfw_pkg::CFG_CLIP_WIDTH, 16'h7FFF);
    add_draw(0, 12, 8'h11, 8'h22, 8'h33, 8'h44, 1, 0);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // long stretch without idling on either side
      stall_on = (phase != 4 && phase != 5);
      write_reg(cpfw_pkg::CFG_PIXEL_FORMAT, 16'($urandom_range(0, 7)));
      write_reg(cpfw_pkg::CFG_CLIP_ENABLE, 16'($urandom_range(99) < 60));
      write_reg(cpfw_pkg::CFG_CLIP_LEFT, clip_origin());
      write_reg(cpfw_pkg::CFG_CLIP_TOP, clip_origin());
      write_reg(cpfw_pkg::CFG_CLIP_WIDTH, clip_span());
      write_reg(cpfw_pkg::CFG_CLIP_HEIGHT, clip_span());
      repeat (PHASE_ITEMS) begin
        if (random_sent == 20 || $urandom_range(99) == 0) drain_results();
        push_cmd(random_cmd(), 1'b0, '0);
        random_sent++;
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
